>>> hdl/bgic_pkg.sv
`default_nettype none
// ============================================================================
// bgic_pkg
// Shared widths, register indexes, pattern codes and reset values for the
// Bayer green imbalance correction block.
// ============================================================================
package bgic_pkg;

    localparam int MAX_WIDTH   = 4096;
    localparam int MAX_HEIGHT  = 4096;
    localparam int PIXEL_BITS  = 16;

    localparam int PIX_W       = 16;
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int ROW_W       = $clog2(MAX_HEIGHT);
    localparam int DIM_W       = 13;
    localparam int BLK_W       = 11;
    localparam int STORE_DEPTH = MAX_WIDTH / 2;
    localparam int THR_W       = 12;
    localparam int STR_W       = 10;
    localparam int IDX_W       = 3;
    localparam int CFG_W       = 13;

    localparam int LIMIT_SHIFT = 8;
    localparam int BLEND_SHIFT = 9;
    localparam int LIM_W       = PIX_W + THR_W;
    localparam int BLEND_W     = PIX_W + STR_W;
    localparam int SAT_W       = LIM_W - LIMIT_SHIFT;

    typedef logic [PIX_W-1:0] pix_t;

    localparam pix_t PIXEL_MAX = pix_t'((32'd1 << PIXEL_BITS) - 1);

    localparam logic [STR_W-1:0]   K_FULL = STR_W'(1 << BLEND_SHIFT);
    localparam logic [BLEND_W-1:0] ROUND  = BLEND_W'(1 << (BLEND_SHIFT - 1));

    localparam logic [IDX_W-1:0] REG_ENABLE    = 3'd0;
    localparam logic [IDX_W-1:0] REG_PATTERN   = 3'd1;
    localparam logic [IDX_W-1:0] REG_WIDTH     = 3'd2;
    localparam logic [IDX_W-1:0] REG_HEIGHT    = 3'd3;
    localparam logic [IDX_W-1:0] REG_THRESHOLD = 3'd4;
    localparam logic [IDX_W-1:0] REG_STRENGTH  = 3'd5;

    localparam logic [1:0] PAT_RGGB = 2'd0;
    localparam logic [1:0] PAT_GRBG = 2'd1;
    localparam logic [1:0] PAT_GBRG = 2'd2;
    localparam logic [1:0] PAT_BGGR = 2'd3;

    localparam logic [1:0]       RST_PATTERN   = PAT_RGGB;
    localparam logic [DIM_W-1:0] RST_WIDTH     = 13'd1920;
    localparam logic [DIM_W-1:0] RST_HEIGHT    = 13'd1080;
    localparam logic [THR_W-1:0] RST_THRESHOLD = 12'd282;
    localparam logic [STR_W-1:0] RST_STRENGTH  = 10'd128;

endpackage
`default_nettype wire

>>> hdl/bayer_green_imbalance_correct.sv
`default_nettype none
// ============================================================================
// bayer_green_imbalance_correct
// Streams raw Bayer pixels, pairs even and odd rows into 2x2 blocks and
// blends the two greens of a block toward each other when their ratio is
// below the programmed threshold.
// ============================================================================
// One raw pixel is accepted per clock while m_tready does not hold the
// pipeline, with no gaps required. Even rows go into a line store (two
// 2048 x 16 RAMs, even and odd columns, registered reads); one block beat
// leaves for every odd-column pixel of an odd row, after that pixel passes
// the RAM read, the multiply stage and the compare and blend stage. Trailing
// odd columns and rows produce no block. s_tuser flags the first pixel of a
// frame. Write the configuration registers only while no block is in flight.
module bayer_green_imbalance_correct
    import bgic_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire logic [15:0]      s_tdata,   // [15:0] pixel_in
    input  wire logic [0:0]       s_tuser,   // [0] frame_start
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output logic      [87:0]      m_tdata,   // [15:0] top_left, [31:16] top_right,
                                             // [47:32] bottom_left,
                                             // [63:48] bottom_right,
                                             // [74:64] block_column,
                                             // [85:75] block_row, [87:86] zero
    output logic      [0:0]       m_tuser,   // [0] was_corrected
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0] cfg_data
);

    localparam int ADDR_W = COL_W - 1;

    // configuration
    logic             enable_reg;
    logic [1:0]       pattern_reg;
    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;
    logic [THR_W-1:0] thr_reg;
    logic [STR_W-1:0] str_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg  <= 1'b1;
            pattern_reg <= RST_PATTERN;
            width_reg   <= RST_WIDTH;
            height_reg  <= RST_HEIGHT;
            thr_reg     <= RST_THRESHOLD;
            str_reg     <= RST_STRENGTH;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_ENABLE:    enable_reg  <= cfg_data[0];
                REG_PATTERN:   pattern_reg <= cfg_data[1:0];
                REG_WIDTH:     width_reg   <= cfg_data;
                REG_HEIGHT:    height_reg  <= cfg_data;
                REG_THRESHOLD: thr_reg     <= cfg_data[THR_W-1:0];
                REG_STRENGTH:  str_reg     <= cfg_data[STR_W-1:0];
                default: ;
            endcase
        end
    end

    // raster position
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [DIM_W-1:0] width_eff, height_eff;
    logic [COL_W-1:0] col_start, col_cur;
    logic [ROW_W-1:0] row_start, row_cur;
    logic [DIM_W-1:0] col_inc, row_inc;
    logic             accept;
    logic             even_row, odd_col, is_block;
    pix_t             pix;

    always_comb begin
        if (width_reg < DIM_W'(2)) begin
            width_eff = DIM_W'(2);
        end else if (width_reg > DIM_W'(MAX_WIDTH)) begin
            width_eff = DIM_W'(MAX_WIDTH);
        end else begin
            width_eff = width_reg;
        end
        if (height_reg < DIM_W'(2)) begin
            height_eff = DIM_W'(2);
        end else if (height_reg > DIM_W'(MAX_HEIGHT)) begin
            height_eff = DIM_W'(MAX_HEIGHT);
        end else begin
            height_eff = height_reg;
        end

        col_start = s_tuser[0] ? '0 : col_reg;
        row_start = s_tuser[0] ? '0 : row_reg;
        col_cur   = (DIM_W'(col_start) >= width_eff)  ? '0 : col_start;
        row_cur   = (DIM_W'(row_start) >= height_eff) ? '0 : row_start;

        col_inc = DIM_W'(col_cur) + DIM_W'(1);
        row_inc = DIM_W'(row_cur) + DIM_W'(1);
        if (col_inc >= width_eff) begin
            col_next = '0;
            row_next = (row_inc >= height_eff) ? '0 : row_inc[ROW_W-1:0];
        end else begin
            col_next = col_inc[COL_W-1:0];
            row_next = row_cur;
        end
    end

    assign pix      = s_tdata & PIXEL_MAX;
    assign accept   = s_tvalid & s_tready;
    assign even_row = ~row_cur[0];
    assign odd_col  = col_cur[0];
    assign is_block = ~even_row & odd_col;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (accept) begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // line store, split by column parity
    pix_t             tl_rd, tr_rd;
    logic [ADDR_W-1:0] addr;

    assign addr = col_cur[COL_W-1:1];

    bgic_ram #(.DATA_W(PIX_W), .DEPTH(STORE_DEPTH)) u_even_col_ram (
        .aclk    (aclk),
        .wr_en   (accept & even_row & ~odd_col),
        .wr_addr (addr),
        .wr_data (pix),
        .rd_en   (accept & is_block),
        .rd_addr (addr),
        .rd_data (tl_rd)
    );

    bgic_ram #(.DATA_W(PIX_W), .DEPTH(STORE_DEPTH)) u_odd_col_ram (
        .aclk    (aclk),
        .wr_en   (accept & even_row & odd_col),
        .wr_addr (addr),
        .wr_data (pix),
        .rd_en   (accept & is_block),
        .rd_addr (addr),
        .rd_data (tr_rd)
    );

    pix_t held_bl_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_bl_reg <= '0;
        end else if (accept && !even_row && !odd_col) begin
            held_bl_reg <= pix;
        end
    end

    // pipeline handshake
    logic v1_reg, v2_reg, v3_reg;
    logic adv1, adv2;

    assign adv2     = ~v3_reg | m_tready;
    assign adv1     = ~v2_reg | adv2;
    assign s_tready = ~v1_reg | adv1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                v1_reg <= accept & is_block;
            end
            if (adv1) begin
                v2_reg <= v1_reg;
            end
            if (adv2) begin
                v3_reg <= v2_reg;
            end
        end
    end

    // stage 1: block bottom row and position, top row arrives from the RAMs
    pix_t             bl1_reg, br1_reg;
    logic [BLK_W-1:0] bcol1_reg, brow1_reg;

    always_ff @(posedge aclk) begin
        if (accept && is_block) begin
            bl1_reg   <= held_bl_reg;
            br1_reg   <= pix;
            bcol1_reg <= BLK_W'(col_cur >> 1);
            brow1_reg <= BLK_W'(row_cur >> 1);
        end
    end

    // stage 2: green selection and products
    logic             diag1;
    pix_t             g1, g2;
    logic [STR_W-1:0] k_sat, k_inv;

    assign diag1 = (pattern_reg == PAT_RGGB) || (pattern_reg == PAT_BGGR);
    assign g1    = diag1 ? tr_rd   : tl_rd;
    assign g2    = diag1 ? bl1_reg : br1_reg;
    assign k_sat = (str_reg > K_FULL) ? K_FULL : str_reg;
    assign k_inv = K_FULL - k_sat;

    pix_t               tl2_reg, tr2_reg, bl2_reg, br2_reg, g1_2_reg, g2_2_reg;
    logic [BLK_W-1:0]   bcol2_reg, brow2_reg;
    logic               diag2_reg;
    logic [LIM_W-1:0]   lim1_reg, lim2_reg;
    logic [BLEND_W-1:0] b1a_reg, b1b_reg, b2a_reg, b2b_reg;

    always_ff @(posedge aclk) begin
        if (adv1 && v1_reg) begin
            tl2_reg   <= tl_rd;
            tr2_reg   <= tr_rd;
            bl2_reg   <= bl1_reg;
            br2_reg   <= br1_reg;
            bcol2_reg <= bcol1_reg;
            brow2_reg <= brow1_reg;
            diag2_reg <= diag1;
            g1_2_reg  <= g1;
            g2_2_reg  <= g2;
            lim1_reg  <= LIM_W'(g1) * LIM_W'(thr_reg);
            lim2_reg  <= LIM_W'(g2) * LIM_W'(thr_reg);
            b1a_reg   <= BLEND_W'(k_inv) * BLEND_W'(g1);
            b1b_reg   <= BLEND_W'(k_sat) * BLEND_W'(g2);
            b2a_reg   <= BLEND_W'(k_inv) * BLEND_W'(g2);
            b2b_reg   <= BLEND_W'(k_sat) * BLEND_W'(g1);
        end
    end

    // stage 3: ratio test and blend
    function automatic pix_t sat_pix(input logic [SAT_W-1:0] v);
        sat_pix = (v > SAT_W'(PIXEL_MAX)) ? PIXEL_MAX : v[PIX_W-1:0];
    endfunction

    pix_t               lim1_sat, lim2_sat, blend1, blend2;
    logic [BLEND_W-1:0] sum1, sum2;
    logic               hit;
    pix_t               tl_next, tr_next, bl_next, br_next;

    always_comb begin
        lim1_sat = sat_pix(lim1_reg[LIM_W-1:LIMIT_SHIFT]);
        lim2_sat = sat_pix(lim2_reg[LIM_W-1:LIMIT_SHIFT]);
        sum1     = b1a_reg + b1b_reg + ROUND;
        sum2     = b2a_reg + b2b_reg + ROUND;
        blend1   = sat_pix(SAT_W'(sum1[BLEND_W-1:BLEND_SHIFT]));
        blend2   = sat_pix(SAT_W'(sum2[BLEND_W-1:BLEND_SHIFT]));
        hit      = enable_reg &&
                   (((g1_2_reg > g2_2_reg) && (g1_2_reg < lim2_sat)) ||
                    ((g2_2_reg > g1_2_reg) && (g2_2_reg < lim1_sat)));

        tl_next = tl2_reg;
        tr_next = tr2_reg;
        bl_next = bl2_reg;
        br_next = br2_reg;
        if (hit) begin
            if (diag2_reg) begin
                tr_next = blend1;
                bl_next = blend2;
            end else begin
                tl_next = blend1;
                br_next = blend2;
            end
        end
    end

    pix_t             tl3_reg, tr3_reg, bl3_reg, br3_reg;
    logic [BLK_W-1:0] bcol3_reg, brow3_reg;
    logic             hit3_reg;

    always_ff @(posedge aclk) begin
        if (adv2 && v2_reg) begin
            tl3_reg   <= tl_next;
            tr3_reg   <= tr_next;
            bl3_reg   <= bl_next;
            br3_reg   <= br_next;
            bcol3_reg <= bcol2_reg;
            brow3_reg <= brow2_reg;
            hit3_reg  <= hit;
        end
    end

    assign m_tvalid = v3_reg;
    assign m_tdata  = {2'b00, brow3_reg, bcol3_reg, br3_reg, bl3_reg, tr3_reg, tl3_reg};
    assign m_tuser  = hit3_reg;

endmodule
`default_nettype wire

>>> hdl/bgic_ram.sv
`default_nettype none
// ============================================================================
// bgic_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ============================================================================
module bgic_ram #(
    parameter int DATA_W = 16,
    parameter int DEPTH  = 2048
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [DATA_W-1:0]        wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [DATA_W-1:0]        rd_data
);

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire
